@@ hdl/pvp_pkg.sv @@
package pvp_pkg;

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] LN2_Q30 = 64'd744261118;
  localparam logic [28:0] GAUSS_W_Q30 = 29'd504356549;
  localparam logic [28:0] LOR_W_Q30 = 29'd341782638;
  localparam logic [30:0] Z_MAX_Q16 = 31'd1 << 30;
  localparam logic [16:0] SHAPE_ONE = 17'h10000;
  localparam int SERIES_TERMS = 24;

  localparam logic [2:0] REG_AMPLITUDE = 3'd0;
  localparam logic [2:0] REG_CENTER = 3'd1;
  localparam logic [2:0] REG_WIDTH = 3'd2;
  localparam logic [2:0] REG_SHAPE = 3'd3;
  localparam logic [2:0] REG_BACKGROUND = 3'd4;

  // Entry i of the 2^-f table in Q30, from a truncated Taylor series of exp(-a).
  function automatic logic [30:0] pow2_entry(input int unsigned i, input int unsigned bits);
    logic [63:0] a;
    logic [63:0] term;
    longint sum;
    int n;
    a = (64'(i) * LN2_Q30 + ((64'd1 << bits) >> 1)) >> bits;
    sum = longint'(ONE_Q30);
    term = ONE_Q30;
    for (n = 1; n <= SERIES_TERMS; n++) begin
      term = ((term * a) >> 30) / 64'(n);
      if ((n & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(ONE_Q30)) begin
      sum = longint'(ONE_Q30);
    end
    return 31'(sum);
  endfunction

endpackage

@@ hdl/pseudo_voigt_peak_eval_unit.sv @@
// Pseudo-Voigt peak evaluator: for each abscissa x_value it returns
// amplitude * (wg * G(z) + (1 - wg) * L(z)) + background in Q16.16.
// Input channel: in_valid, x_value, in_stall. A transfer happens on a rising
// edge with in_valid high and in_stall low. Output channel: out_valid,
// y_value, param_error, out_stall, with the same rule.
// Configuration: cfg_wr_en, cfg_index and cfg_data write one register per
// cycle; write only while no item is in flight.
// The two 31-stage restoring dividers (z and the Lorentzian) lie in series
// on the path from input transfer to result.
// Throughput is one item per cycle while no stalled result waits; the pipeline has no loops.
// Reset clears all valid bits and loads the register defaults.
// When out_stall holds a waiting result, the whole pipeline freezes and
// in_stall rises in the same cycle, so nothing is lost or repeated.
module pseudo_voigt_peak_eval_unit #(
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] x_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] y_value,
  output logic        param_error,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import pvp_pkg::*;

  localparam int QZ = 31;
  localparam int QL = 31;
  localparam int QW = 17;
  localparam int GL = 3;
  localparam int T_Z = 1 + QZ;
  localparam int T_E = T_Z + 1;
  localparam int T_L = T_E + QL;
  localparam int T_W = 1 + QW;
  localparam int T_Y = T_L + 4;

  logic signed [31:0] amplitude;
  logic signed [31:0] center;
  logic signed [31:0] width;
  logic [16:0] shape;
  logic signed [31:0] background;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude <= 32'sd65536;
      center <= '0;
      width <= 32'sd65536;
      shape <= 17'd32768;
      background <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_AMPLITUDE: amplitude <= cfg_data;
        REG_CENTER: center <= cfg_data;
        REG_WIDTH: width <= cfg_data;
        REG_SHAPE: shape <= cfg_data[16:0];
        REG_BACKGROUND: background <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  logic [31:0] aw;
  logic [31:0] am;
  assign aw = width[31] ? 32'(-width) : width;
  assign am = amplitude[31] ? 32'(-amplitude) : amplitude;

  logic [32:0] dd;
  logic [32:0] ad;
  logic [45:0] wnum;
  logic [46:0] wden;
  logic [45:0] wnum_next;
  logic [46:0] wden_next;

  assign dd = {x_value[31], x_value} - {center[31], center};
  assign wnum_next = shape * GAUSS_W_Q30;
  assign wden_next = {1'b0, wnum_next} + 47'(SHAPE_ONE - shape) * 47'(LOR_W_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      ad <= dd[32] ? 33'(-dd) : dd;
      wnum <= wnum_next;
      wden <= wden_next;
    end
  end

  logic sat;
  logic sat_d;
  logic [30:0] zq;
  assign sat = {14'd0, ad[32:15]} >= aw;

  pvp_div_pipe #(.QW(QZ), .DW(32)) u_zdiv (
    .clk(clk), .en(en),
    .r0(sat ? 32'd0 : {14'd0, ad[32:15]}),
    .bits({ad[14:0], 16'd0}),
    .d(aw),
    .q(zq)
  );

  pvp_delay #(.W(1), .DEPTH(QZ)) u_sat_dly (
    .clk(clk), .rst(rst), .en(en), .din(sat), .dout(sat_d)
  );

  logic [16:0] wg;
  pvp_div_pipe #(.QW(QW), .DW(47)) u_wdiv (
    .clk(clk), .en(en),
    .r0({2'b00, wnum[45:1]}),
    .bits({wnum[0], 16'd0}),
    .d(wden),
    .q(wg)
  );

  logic [30:0] zc;
  logic [60:0] zsq;
  logic [62:0] e;
  assign zc = (sat_d || zq > Z_MAX_Q16) ? Z_MAX_Q16 : zq;
  assign zsq = zc * zc;

  always_ff @(posedge clk) begin
    if (en) begin
      e <= {zsq, 2'b00};
    end
  end

  logic [30:0] l30;
  pvp_div_pipe #(.QW(QL), .DW(63)) u_ldiv (
    .clk(clk), .en(en),
    .r0(63'd1 << 31),
    .bits('0),
    .d((63'd1 << 32) + e),
    .q(l30)
  );

  logic [30:0] g30;
  logic [30:0] g30_d;
  pvp_gauss #(.TB(EXP_TABLE_BITS)) u_gauss (
    .clk(clk), .en(en), .e(e), .g30(g30)
  );

  pvp_delay #(.W(31), .DEPTH(QL - GL)) u_g_dly (
    .clk(clk), .rst(rst), .en(en), .din(g30), .dout(g30_d)
  );

  logic [16:0] wg_d;
  pvp_delay #(.W(17), .DEPTH(T_L - T_W)) u_w_dly (
    .clk(clk), .rst(rst), .en(en), .din(wg), .dout(wg_d)
  );

  logic [47:0] pg;
  logic [47:0] pl;
  logic [30:0] p30;
  logic [48:0] psum;
  logic [62:0] aprod;
  logic [32:0] mag;
  assign psum = {1'b0, pg} + {1'b0, pl};
  assign aprod = am * p30;

  always_ff @(posedge clk) begin
    if (en) begin
      pg <= wg_d * g30_d;
      pl <= (SHAPE_ONE - wg_d) * l30;
      p30 <= psum[46:16];
      mag <= aprod[62:30];
    end
  end

  localparam logic signed [34:0] Y_MAX = 35'sd2147483647;
  localparam logic signed [34:0] Y_MIN = -35'sd2147483648;

  logic signed [34:0] smag;
  logic signed [34:0] ysum;
  logic [31:0] ysat;
  logic err;

  assign smag = amplitude[31] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
  assign ysum = smag + 35'(background);
  assign ysat = (ysum > Y_MAX) ? 32'h7fffffff :
                (ysum < Y_MIN) ? 32'h80000000 : ysum[31:0];
  assign err = (aw == 32'd0) || (shape > SHAPE_ONE);

  always_ff @(posedge clk) begin
    if (en) begin
      y_value <= err ? 32'd0 : ysat;
      param_error <= err;
    end
  end

  pvp_delay #(.W(1), .DEPTH(T_Y)) u_v_dly (
    .clk(clk), .rst(rst), .en(en), .din(in_valid), .dout(out_valid)
  );

endmodule

@@ hdl/pvp_delay.sv @@
module pvp_delay #(
  parameter int W = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        line[i] <= '0;
      end
    end else if (en) begin
      line[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign dout = line[DEPTH-1];

endmodule

@@ hdl/pvp_div_pipe.sv @@
module pvp_div_pipe #(
  parameter int QW = 31,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] r0,
  input  logic [QW-1:0] bits,
  input  logic [DW-1:0] d,
  output logic [QW-1:0] q
);

  logic [DW-1:0] rem [QW];
  logic [QW-1:0] qq [QW];
  logic [DW-1:0] dv [QW-1];
  logic [QW-1:0] nb [QW-1];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [DW-1:0] rin;
    logic [DW-1:0] din;
    logic [QW-1:0] bin;
    logic [QW-1:0] qin;
    logic [DW:0] t;
    logic ge;

    if (j == 0) begin : g_first
      assign rin = r0;
      assign din = d;
      assign bin = bits;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem[j-1];
      assign din = dv[j-1];
      assign bin = nb[j-1];
      assign qin = qq[j-1];
    end

    assign t = {rin, bin[QW-1]};
    assign ge = t >= {1'b0, din};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= ge ? DW'(t - {1'b0, din}) : t[DW-1:0];
        qq[j] <= {qin[QW-2:0], ge};
      end
    end

    if (j < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          dv[j] <= din;
          nb[j] <= bin << 1;
        end
      end
    end
  end

  assign q = qq[QW-1];

endmodule

@@ hdl/pvp_gauss.sv @@
module pvp_gauss #(
  parameter int TB = 8
) (
  input  logic        clk,
  input  logic        en,
  input  logic [62:0] e,
  output logic [30:0] g30
);
  import pvp_pkg::*;

  localparam int FB = 32 - TB;
  localparam int TN = 1 << TB;

  logic [30:0] tbl [TN+1];

  for (genvar i = 0; i <= TN; i++) begin : g_tbl
    assign tbl[i] = pow2_entry(i, TB);
  end

  logic [TB-1:0] idx;
  logic [TB:0] idx0;
  logic [TB:0] idx1;
  logic [30:0] t0, t1;
  logic [FB-1:0] frac;
  logic [4:0] ks;
  logic kill;

  assign idx = e[31:FB];
  assign idx0 = {1'b0, idx};
  assign idx1 = idx0 + 1'b1;

  always_ff @(posedge clk) begin
    if (en) begin
      t0 <= tbl[idx0];
      t1 <= tbl[idx1];
      frac <= e[FB-1:0];
      ks <= e[36:32];
      kill <= e[62:32] >= 31'd31;
    end
  end

  logic [30:0] t0b;
  logic [FB+30:0] pm;
  logic dneg;
  logic [4:0] ks2;
  logic kill2;
  logic [30:0] dm;

  assign dm = (t0 > t1) ? t0 - t1 : t1 - t0;

  always_ff @(posedge clk) begin
    if (en) begin
      t0b <= t0;
      dneg <= t0 > t1;
      pm <= dm * frac;
      ks2 <= ks;
      kill2 <= kill;
    end
  end

  logic [30:0] qf;
  logic [30:0] g;

  assign qf = 31'(pm >> FB);
  assign g = dneg ? t0b - qf : t0b + qf;

  always_ff @(posedge clk) begin
    if (en) begin
      g30 <= kill2 ? '0 : g >> ks2;
    end
  end

endmodule

@@ tb/sv/tb_pseudo_voigt_peak_eval_unit.sv @@
module tb_pseudo_voigt_peak_eval_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import pvp_pkg::*;

  localparam int TBL_BITS = 8;
  localparam int TBL_LEN = (1 << TBL_BITS) + 1;
  localparam int SETTLE_CYCLES = 90;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [2:0] REG_UNUSED_LO = 3'd5;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [31:0] y;
    logic        err;
  } peak_result_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [31:0] data;
    bit          typed;
    logic [31:0] y;
    logic        err;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] x_value;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] y_value;
  logic        param_error;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  pseudo_voigt_peak_eval_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .x_value(x_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .y_value(y_value), .param_error(param_error),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  longint       pow2_q30[TBL_LEN];
  longint       amp_r;
  longint       cen_r;
  longint       wid_r;
  logic [16:0]  shape_r;
  longint       bg_r;
  peak_result_t pending_peaks[$];
  int           mismatches;
  int           items_sent;
  int           results_seen;
  int           error_results;
  int           send_idle_pct;
  int           recv_idle_pct;
  bit           hold_request;
  int           stuck_cycles;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic longint neg_exp_q30(input logic [63:0] a);
    longint      acc;
    logic [63:0] term;
    acc = longint'(ONE_Q30);
    term = ONE_Q30;
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      term = ((term * a) >> 30) / 64'(n);
      acc = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
    return acc;
  endfunction

  function automatic peak_result_t peak_predict(input logic [31:0] xv);
    peak_result_t r;
    longint      x, d, g, mag, y;
    logic [63:0] aw, ad, zq, e, k, f, idx, frac, l30, g30, wnum, wden, wg, p30, aa;
    aw = 64'(wid_r < 0 ? -wid_r : wid_r);
    if (aw == 0 || shape_r > SHAPE_ONE) begin
      r.y = '0;
      r.err = 1'b1;
      return r;
    end
    x = longint'($signed(xv));
    d = x - cen_r;
    ad = 64'(d < 0 ? -d : d);
    zq = (ad << 16) / aw;
    if (zq > 64'(Z_MAX_Q16)) zq = 64'(Z_MAX_Q16);
    e = (zq * zq) << 2;
    l30 = (64'd1 << 62) / ((64'd1 << 32) + e);
    k = e >> 32;
    if (k >= 31) begin
      g30 = 0;
    end else begin
      f = e & 64'hffff_ffff;
      idx = f >> (32 - TBL_BITS);
      frac = f & ((64'd1 << (32 - TBL_BITS)) - 1);
      g = pow2_q30[idx] + ((pow2_q30[idx + 1] - pow2_q30[idx]) * longint'(frac))
          / (longint'(1) << (32 - TBL_BITS));
      if (g < 0) g = 0;
      g30 = 64'(g) >> k;
    end
    wnum = 64'(shape_r) * 64'(GAUSS_W_Q30);
    wden = wnum + (64'd65536 - 64'(shape_r)) * 64'(LOR_W_Q30);
    wg = (wnum << 16) / wden;
    p30 = (wg * g30 + (64'd65536 - wg) * l30) >> 16;
    aa = 64'(amp_r < 0 ? -amp_r : amp_r);
    mag = longint'((aa * p30) >> 30);
    y = (amp_r < 0 ? -mag : mag) + bg_r;
    if (y > 64'sd2147483647) y = 64'sd2147483647;
    if (y < -64'sd2147483648) y = -64'sd2147483648;
    r.y = y[31:0];
    r.err = 1'b0;
    return r;
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_AMPLITUDE: amp_r = longint'($signed(data));
      REG_CENTER: cen_r = longint'($signed(data));
      REG_WIDTH: wid_r = longint'($signed(data));
      REG_SHAPE: shape_r = data[16:0];
      REG_BACKGROUND: bg_r = longint'($signed(data));
      default: ;
    endcase
  endtask

  task automatic cfg_close();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_peaks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_x(input logic [31:0] xv, input bit typed, input peak_result_t typed_res);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      x_value <= $urandom;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    x_value <= xv;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    pending_peaks.push_back(typed ? typed_res : peak_predict(xv));
    items_sent++;
  endtask

  task automatic random_config();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      default: v = 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
    cfg_write(REG_AMPLITUDE, v);
    v = ($urandom_range(0, 4) == 0) ? $urandom : 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    cfg_write(REG_CENTER, v);
    case ($urandom_range(0, 9))
      0: v = 32'd0;
      1: v = $urandom;
      2: v = ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      default: begin
        v = 32'($urandom_range(1 << 10, 1 << 20));
        if ($urandom_range(0, 1) != 0) v = -v;
      end
    endcase
    cfg_write(REG_WIDTH, v);
    case ($urandom_range(0, 7))
      0: v = 32'($urandom_range(65537, 131071)) | ($urandom & 32'hfffe_0000);
      1: v = ($urandom_range(0, 1) != 0) ? 32'd0 : 32'd65536;
      default: v = 32'($urandom_range(0, 65536));
    endcase
    cfg_write(REG_SHAPE, v);
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      default: v = 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
    cfg_write(REG_BACKGROUND, v);
    cfg_write(3'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom);
    cfg_close();
  endtask

  function automatic logic [31:0] random_x();
    longint aw, span;
    aw = wid_r < 0 ? -wid_r : wid_r;
    span = aw * 4;
    if (span > (longint'(1) << 28)) span = longint'(1) << 28;
    if (span < 1) span = 1;
    if ($urandom_range(0, 9) < 6)
      return 32'(cen_r + longint'($urandom_range(0, 32'(2 * span))) - span);
    return $urandom;
  endfunction

  always @(negedge clk) begin
    int hold_left;
    if (hold_request && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    peak_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (param_error) error_results++;
      if (pending_peaks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result y=%h err=%b", y_value, param_error);
      end else begin
        want = pending_peaks.pop_front();
        if (want.y !== y_value || want.err !== param_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected y=%h err=%b, got y=%h err=%b",
                     want.y, want.err, y_value, param_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t    rows[$];
    peak_result_t typed_res;
    rst = 1'b1;
    in_valid = 1'b0;
    x_value = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_request = 1'b0;
    stuck_cycles = 0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    error_results = 0;
    send_idle_pct = 32;
    recv_idle_pct = 52;
    for (int i = 0; i < TBL_LEN; i++)
      pow2_q30[i] = neg_exp_q30((64'(i) * LN2_Q30 + 64'(TBL_LEN / 2)) >> TBL_BITS);
    amp_r = 65536;
    cen_r = 0;
    wid_r = 65536;
    shape_r = 17'd32768;
    bg_r = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    rows = '{
      '{0, 0, 32'h0000_0000, 1, 32'h0001_0000, 0},
      '{0, 0, 32'h7fff_ffff, 0, 0, 0},
      '{0, 0, 32'h8000_0000, 0, 0, 0},
      '{0, 0, 32'h0001_0000, 0, 0, 0},
      '{0, 0, 32'hffff_8000, 0, 0, 0},
      '{1, REG_WIDTH, 32'h0000_0000, 0, 0, 0},
      '{0, 0, 32'h1234_5678, 1, 32'h0000_0000, 1},
      '{1, REG_WIDTH, 32'hffff_0000, 0, 0, 0},
      '{1, REG_SHAPE, 32'h0001_0001, 0, 0, 0},
      '{0, 0, 32'h0000_0000, 1, 32'h0000_0000, 1},
      '{1, REG_SHAPE, 32'h0001_ffff, 0, 0, 0},
      '{0, 0, 32'h0000_0000, 1, 32'h0000_0000, 1},
      '{1, REG_SHAPE, 32'h0001_0000, 0, 0, 0},
      '{0, 0, 32'h0000_0000, 1, 32'h0001_0000, 0},
      '{0, 0, 32'h0002_0000, 0, 0, 0},
      '{1, REG_SHAPE, 32'h0000_0000, 0, 0, 0},
      '{0, 0, 32'h0000_0000, 1, 32'h0001_0000, 0},
      '{1, REG_AMPLITUDE, 32'h7fff_ffff, 0, 0, 0},
      '{0, 0, 32'h0000_0000, 1, 32'h7fff_ffff, 0},
      '{1, REG_BACKGROUND, 32'h7fff_ffff, 0, 0, 0},
      '{0, 0, 32'h0000_0000, 1, 32'h7fff_ffff, 0},
      '{1, REG_AMPLITUDE, 32'h8000_0000, 0, 0, 0},
      '{1, REG_BACKGROUND, 32'h8000_0000, 0, 0, 0},
      '{0, 0, 32'h0000_0000, 1, 32'h8000_0000, 0},
      '{1, REG_CENTER, 32'h8000_0000, 0, 0, 0},
      '{0, 0, 32'h7fff_ffff, 0, 0, 0},
      '{1, REG_CENTER, 32'h7fff_ffff, 0, 0, 0},
      '{0, 0, 32'h8000_0000, 0, 0, 0}
    };
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        cfg_write(rows[i].idx, rows[i].data);
        cfg_close();
      end else begin
        typed_res.y = rows[i].y;
        typed_res.err = rows[i].err;
        send_x(rows[i].data, rows[i].typed, typed_res);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 52 : 0;
      recv_idle_pct = (mode == 0) ? 52 : (mode == 1) ? 32 : 0;
      for (int phase = 0; phase < 9; phase++) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        random_config();
        if (mode == 2 && phase == 1) hold_request = 1'b1;
        for (int n = 0; n < 50; n++) send_x(random_x(), 0, typed_res);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();

    $display("Sent %0d abscissae over 27 random register settings; checked %0d results,",
             items_sent, results_seen);
    $display("%0d with the parameter error flag, %0d mismatches.", error_results, mismatches);
    if (mismatches == 0 && pending_peaks.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
